FILE: rtl/rctr_pkg.sv
// Shared types and constants for the rotated cube texel remap block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package rctr_pkg;

   localparam int MAX_FACE_SIZE = 4096;
   localparam int MAX_CUBES     = 64;
   localparam int FS_W          = 13;
   localparam int N_W           = $clog2(MAX_FACE_SIZE + 1);

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ZERO         = 2'd1,
      ST_BAD_ORDER    = 2'd2,
      ST_OUT_OF_LEVEL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_FACE_SIZE  = 3'd0,
      CSR_ROW_X      = 3'd1,
      CSR_ROW_Y      = 3'd2,
      CSR_ROW_Z      = 3'd3,
      CSR_FACE_ORDER = 3'd4,
      CSR_CUBE_INDEX = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      FACE_PX = 3'd0,
      FACE_NX = 3'd1,
      FACE_PY = 3'd2,
      FACE_NY = 3'd3,
      FACE_PZ = 3'd4,
      FACE_NZ = 3'd5
   } face_type;

   typedef struct packed {
      logic [N_W-1:0] n;
      status_type     status;
      logic [2:0]     face;
      logic           neg;
   } centre_tag_type;

   typedef struct packed {
      logic [N_W-1:0] n;
      status_type     status;
   } item_tag_type;

   typedef struct packed {
      logic [N_W-1:0] n;
      logic [2:0]     face;
   } texel_tag_type;

   function automatic logic [2:0] fo_entry(input logic [17:0] order, input logic [2:0] idx);
      logic [2:0] res;
      case (idx)
         3'd0: res = order[2:0];
         3'd1: res = order[5:3];
         3'd2: res = order[8:6];
         3'd3: res = order[11:9];
         3'd4: res = order[14:12];
         3'd5: res = order[17:15];
         default: res = 3'd0;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/rctr_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Carries a sideband tag alongside; stage enables come from the caller.
`timescale 1ns / 1ps

module rctr_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 14,
   parameter int Q_W   = 16,
   parameter int SPS   = 2,
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic [Q_W/SPS-1:0]     stage_en,
   input  logic [DVD_W-1:0]       dividend,
   input  logic [DVS_W-1:0]       divisor,
   input  logic [TAG_W-1:0]       tag_i,
   output logic [Q_W-1:0]         quotient,
   output logic [TAG_W-1:0]       tag_o
);

   localparam int NS = Q_W / SPS;
   localparam int RW = DVS_W + Q_W;

   logic [RW-1:0]    rem_ff [NS];
   logic [Q_W-1:0]   quo_ff [NS];
   logic [DVS_W-1:0] dvs_ff [NS];
   logic [TAG_W-1:0] tag_ff [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [RW-1:0]    rem_src;
      logic [RW-1:0]    rem_in;
      logic [Q_W-1:0]   quo_src;
      logic [Q_W-1:0]   quo_in;
      logic [DVS_W-1:0] dvs_src;
      logic [TAG_W-1:0] tag_src;
      logic [RW:0]      trial;

      if (g == 0) begin : g_head
         assign rem_src = RW'(dividend);
         assign quo_src = '0;
         assign dvs_src = divisor;
         assign tag_src = tag_i;
      end else begin : g_body
         assign rem_src = rem_ff[g-1];
         assign quo_src = quo_ff[g-1];
         assign dvs_src = dvs_ff[g-1];
         assign tag_src = tag_ff[g-1];
      end

      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         trial  = '0;
         for (int k = 0; k < SPS; k++) begin
            trial = {1'b0, rem_in} - ({{(Q_W + 1){1'b0}}, dvs_src} << (Q_W - 1 - g * SPS - k));
            if (!trial[RW]) begin
               rem_in = trial[RW-1:0];
               quo_in[Q_W - 1 - g * SPS - k] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[g]) begin
            quo_ff[g] <= quo_in;
            tag_ff[g] <= tag_src;
         end
      end

      if (g < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[g]) begin
               rem_ff[g] <= rem_in;
               dvs_ff[g] <= dvs_src;
            end
         end
      end
   end

   assign quotient = quo_ff[NS-1];
   assign tag_o    = tag_ff[NS-1];

endmodule

FILE: rtl/rotated_cube_texel_remap_top.sv
// Top level of the rotated cube texel remap block: configuration registers,
// texel centre, rotation, face selection and texel pipeline.
// Depends on rctr_pkg and rctr_div.
//
// Usage. Target texels arrive on the req_ channel and one result per texel
// leaves on the rsp_ channel, both valid/ready; a transfer happens on a
// clock edge with valid and ready both high. The pipeline has 28 register
// stages, and a result is presented from the stage 27 register. A new texel
// can enter every cycle while the receiver keeps rsp_ready high, giving one
// result per cycle; the centre and texel dividers are fully pipelined (the
// centre dividers, two quotient bits per stage, and the texel dividers, one
// bit per stage).
// When the receiver stalls, each full stage holds only while the one after it
// also holds, so empty stages ahead of a stall still fill and req_ready stays
// high until the whole pipeline is occupied. Nothing is lost or repeated.
// Configuration is written on the csr_ port, one register per cycle with
// csr_we high. It must be written only while no texel is in flight; the
// block does not enforce this. Synchronous reset empties the pipeline and
// restores face size 1, the identity matrix, natural face order and cube 0.
`timescale 1ns / 1ps

module rotated_cube_texel_remap_top
   import rctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mip_level,
   input  logic [2:0]  req_target_face,
   input  logic [11:0] req_texel_x,
   input  logic [11:0] req_texel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_source_face,
   output logic [8:0]  rsp_source_layer,
   output logic [11:0] rsp_source_u,
   output logic [11:0] rsp_source_v,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int NSTG = 28;

   logic [FS_W-1:0] face_size_ff;
   logic [47:0]     row_ff [3];
   logic [17:0]     face_order_ff;
   logic [5:0]      cube_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff  <= FS_W'(1);
         row_ff[0]     <= 48'h0000_0000_4000;
         row_ff[1]     <= 48'h0000_4000_0000;
         row_ff[2]     <= 48'h4000_0000_0000;
         face_order_ff <= {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
         cube_index_ff <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FACE_SIZE:  face_size_ff  <= csr_wdata[FS_W-1:0];
            CSR_ROW_X:      row_ff[0]     <= csr_wdata;
            CSR_ROW_Y:      row_ff[1]     <= csr_wdata;
            CSR_ROW_Z:      row_ff[2]     <= csr_wdata;
            CSR_FACE_ORDER: face_order_ff <= csr_wdata[17:0];
            CSR_CUBE_INDEX: cube_index_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage loads when it is empty or its item moves on.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG:0]   en;

   assign en[NSTG] = rsp_ready;
   for (genvar i = 0; i < NSTG; i++) begin : g_en
      assign en[i] = ~vld_ff[i] | en[i+1];
   end
   assign vld_in = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // Stage 0: level size, checks and centre dividends.
   logic [FS_W-1:0] fs_cl;
   logic [N_W-1:0]  n_sh;
   logic [N_W-1:0]  n_lvl;
   logic            bad_order;
   logic            oob;
   logic [14:0]     num_s;
   logic [14:0]     num_t;
   logic [14:0]     mag_s;
   logic [14:0]     mag_t;
   status_type      st0;

   logic [29:0]     dvd_s_ff;
   logic [29:0]     dvd_t_ff;
   logic [13:0]     dvs_c_ff;
   centre_tag_type  ctag_ff;
   logic            neg_t_ff;

   always_comb begin
      fs_cl = (int'(face_size_ff) > MAX_FACE_SIZE) ? FS_W'(MAX_FACE_SIZE) : face_size_ff;
      n_sh  = N_W'(fs_cl >> req_mip_level);
      n_lvl = (n_sh == '0) ? N_W'(1) : n_sh;
      bad_order = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (fo_entry(face_order_ff, 3'(i)) > 3'd5) begin
            bad_order = 1'b1;
         end
      end
      oob = ({1'b0, req_texel_x} >= n_lvl) || ({1'b0, req_texel_y} >= n_lvl);
      if (bad_order) begin
         st0 = ST_BAD_ORDER;
      end else if (oob) begin
         st0 = ST_OUT_OF_LEVEL;
      end else begin
         st0 = ST_OK;
      end
      num_s = {2'b00, req_texel_x, 1'b1} - {2'b00, n_lvl};
      num_t = {2'b00, req_texel_y, 1'b1} - {2'b00, n_lvl};
      mag_s = num_s[14] ? (15'd0 - num_s) : num_s;
      mag_t = num_t[14] ? (15'd0 - num_t) : num_t;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dvd_s_ff       <= {1'b0, mag_s[11:0], 17'd0} + 30'(n_lvl);
         dvd_t_ff       <= {1'b0, mag_t[11:0], 17'd0} + 30'(n_lvl);
         dvs_c_ff       <= {n_lvl, 1'b0};
         ctag_ff.n      <= n_lvl;
         ctag_ff.status <= st0;
         ctag_ff.face   <= req_target_face;
         ctag_ff.neg    <= num_s[14];
         neg_t_ff       <= num_t[14];
      end
   end

   // Stages 1 to 8: texel centre quotients.
   logic [15:0]    q_s;
   logic [15:0]    q_t;
   centre_tag_type ctag_o;
   logic           neg_t_o;

   rctr_div #(
      .DVD_W (30),
      .DVS_W (14),
      .Q_W   (16),
      .SPS   (2),
      .TAG_W ($bits(centre_tag_type))
   ) u_div_s (
      .clock    (clock),
      .stage_en (en[8:1]),
      .dividend (dvd_s_ff),
      .divisor  (dvs_c_ff),
      .tag_i    (ctag_ff),
      .quotient (q_s),
      .tag_o    (ctag_o)
   );

   rctr_div #(
      .DVD_W (30),
      .DVS_W (14),
      .Q_W   (16),
      .SPS   (2),
      .TAG_W (1)
   ) u_div_t (
      .clock    (clock),
      .stage_en (en[8:1]),
      .dividend (dvd_t_ff),
      .divisor  (dvs_c_ff),
      .tag_i    (neg_t_ff),
      .quotient (q_t),
      .tag_o    (neg_t_o)
   );

   // Stage 9: face direction.
   localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

   logic signed [17:0] s_val;
   logic signed [17:0] t_val;
   logic signed [17:0] d_in [3];
   logic signed [17:0] d_ff [3];
   item_tag_type       itag9_ff;

   always_comb begin
      s_val = ctag_o.neg ? -$signed({2'b00, q_s}) : $signed({2'b00, q_s});
      t_val = neg_t_o ? -$signed({2'b00, q_t}) : $signed({2'b00, q_t});
      case (ctag_o.face)
         FACE_PX: begin
            d_in[0] = ONE_Q16;  d_in[1] = -t_val;   d_in[2] = -s_val;
         end
         FACE_NX: begin
            d_in[0] = -ONE_Q16; d_in[1] = -t_val;   d_in[2] = s_val;
         end
         FACE_PY: begin
            d_in[0] = s_val;    d_in[1] = ONE_Q16;  d_in[2] = t_val;
         end
         FACE_NY: begin
            d_in[0] = s_val;    d_in[1] = -ONE_Q16; d_in[2] = -t_val;
         end
         FACE_PZ: begin
            d_in[0] = s_val;    d_in[1] = -t_val;   d_in[2] = ONE_Q16;
         end
         default: begin
            d_in[0] = -s_val;   d_in[1] = -t_val;   d_in[2] = -ONE_Q16;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         d_ff            <= d_in;
         itag9_ff.n      <= ctag_o.n;
         itag9_ff.status <= ctag_o.status;
      end
   end

   // Stage 10: nine products of coefficient and component.
   logic signed [33:0] prod_in [3][3];
   logic signed [33:0] prod_ff [3][3];
   item_tag_type       itag10_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(row_ff[i][16*j +: 16]) * d_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         prod_ff   <= prod_in;
         itag10_ff <= itag9_ff;
      end
   end

   // Stage 11: rotated components.
   logic signed [35:0] p_in [3];
   logic signed [35:0] p_ff [3];
   item_tag_type       itag11_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = {{2{prod_ff[i][0][33]}}, prod_ff[i][0]}
                 + {{2{prod_ff[i][1][33]}}, prod_ff[i][1]}
                 + {{2{prod_ff[i][2][33]}}, prod_ff[i][2]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[11]) begin
         p_ff      <= p_in;
         itag11_ff <= itag10_ff;
      end
   end

   // Stage 12: major axis selection.
   logic [35:0]        ax;
   logic [35:0]        ay;
   logic [35:0]        az;
   logic               pos_x;
   logic               pos_y;
   logic               pos_z;
   logic [2:0]         from_in;
   logic [32:0]        major_in;
   logic signed [35:0] sc_in;
   logic signed [35:0] tc_in;
   status_type         st12;

   logic [2:0]         from_ff;
   logic [32:0]        major_ff;
   logic signed [35:0] sc_ff;
   logic signed [35:0] tc_ff;
   item_tag_type       itag12_ff;

   always_comb begin
      ax = p_ff[0][35] ? 36'(-p_ff[0]) : 36'(p_ff[0]);
      ay = p_ff[1][35] ? 36'(-p_ff[1]) : 36'(p_ff[1]);
      az = p_ff[2][35] ? 36'(-p_ff[2]) : 36'(p_ff[2]);
      pos_x = !p_ff[0][35] && (p_ff[0] != '0);
      pos_y = !p_ff[1][35] && (p_ff[1] != '0);
      pos_z = !p_ff[2][35] && (p_ff[2] != '0);
      if (ax >= ay && ax >= az) begin
         from_in  = pos_x ? FACE_PX : FACE_NX;
         major_in = ax[32:0];
         sc_in    = pos_x ? -p_ff[2] : p_ff[2];
         tc_in    = -p_ff[1];
      end else if (ay >= az) begin
         from_in  = pos_y ? FACE_PY : FACE_NY;
         major_in = ay[32:0];
         sc_in    = p_ff[0];
         tc_in    = pos_y ? p_ff[2] : -p_ff[2];
      end else begin
         from_in  = pos_z ? FACE_PZ : FACE_NZ;
         major_in = az[32:0];
         sc_in    = pos_z ? p_ff[0] : -p_ff[0];
         tc_in    = -p_ff[1];
      end
      st12 = itag11_ff.status;
      if (st12 == ST_OK && major_in == '0) begin
         st12 = ST_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (en[12]) begin
         from_ff          <= from_in;
         major_ff         <= major_in;
         sc_ff            <= sc_in;
         tc_ff            <= tc_in;
         itag12_ff.n      <= itag11_ff.n;
         itag12_ff.status <= st12;
      end
   end

   // Stage 13: texel numerators and divisor.
   logic [35:0]    sum_u;
   logic [35:0]    sum_v;
   logic [46:0]    num_u_ff;
   logic [46:0]    num_v_ff;
   logic [33:0]    dvs_t_ff;
   texel_tag_type  ttag_ff;
   status_type     st13_ff;

   always_comb begin
      sum_u = 36'(sc_ff) + {3'b000, major_ff};
      sum_v = 36'(tc_ff) + {3'b000, major_ff};
   end

   always_ff @(posedge clock) begin
      if (en[13]) begin
         num_u_ff     <= 47'(sum_u[33:0]) * 47'(itag12_ff.n);
         num_v_ff     <= 47'(sum_v[33:0]) * 47'(itag12_ff.n);
         dvs_t_ff     <= (major_ff == '0) ? 34'd1 : {major_ff, 1'b0};
         ttag_ff.n    <= itag12_ff.n;
         ttag_ff.face <= from_ff;
         st13_ff      <= itag12_ff.status;
      end
   end

   // Stages 14 to 26: source texel quotients.
   logic [12:0]   q_u;
   logic [12:0]   q_v;
   texel_tag_type ttag_o;
   logic [1:0]    st_o;

   rctr_div #(
      .DVD_W (47),
      .DVS_W (34),
      .Q_W   (13),
      .SPS   (1),
      .TAG_W ($bits(texel_tag_type))
   ) u_div_u (
      .clock    (clock),
      .stage_en (en[26:14]),
      .dividend (num_u_ff),
      .divisor  (dvs_t_ff),
      .tag_i    (ttag_ff),
      .quotient (q_u),
      .tag_o    (ttag_o)
   );

   rctr_div #(
      .DVD_W (47),
      .DVS_W (34),
      .Q_W   (13),
      .SPS   (1),
      .TAG_W ($bits(status_type))
   ) u_div_v (
      .clock    (clock),
      .stage_en (en[26:14]),
      .dividend (num_v_ff),
      .divisor  (dvs_t_ff),
      .tag_i    (st13_ff),
      .quotient (q_v),
      .tag_o    (st_o)
   );

   // Stage 27: clamp, layer and result register.
   logic [N_W-1:0] n_m1;
   logic [12:0]    u_cl;
   logic [12:0]    v_cl;
   logic [5:0]     ci_cl;
   logic [8:0]     layer;

   logic [1:0]     status_ff;
   logic [2:0]     face_ff;
   logic [8:0]     layer_ff;
   logic [11:0]    u_ff;
   logic [11:0]    v_ff;

   always_comb begin
      n_m1  = ttag_o.n - N_W'(1);
      u_cl  = (q_u > 13'(n_m1)) ? 13'(n_m1) : q_u;
      v_cl  = (q_v > 13'(n_m1)) ? 13'(n_m1) : q_v;
      ci_cl = (int'(cube_index_ff) >= MAX_CUBES) ? 6'(MAX_CUBES - 1) : cube_index_ff;
      layer = ({3'b000, ci_cl} * 9'd6) + {6'd0, fo_entry(face_order_ff, ttag_o.face)};
   end

   always_ff @(posedge clock) begin
      if (en[27]) begin
         status_ff <= st_o;
         if (st_o == ST_OK) begin
            face_ff  <= ttag_o.face;
            layer_ff <= layer;
            u_ff     <= u_cl[11:0];
            v_ff     <= v_cl[11:0];
         end else begin
            face_ff  <= 3'd0;
            layer_ff <= 9'd0;
            u_ff     <= 12'd0;
            v_ff     <= 12'd0;
         end
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_source_face  = face_ff;
   assign rsp_source_layer = layer_ff;
   assign rsp_source_u     = u_ff;
   assign rsp_source_v     = v_ff;

endmodule
